/* hw/rtl/stfe_pkg.sv */
// Package for the sine tone generator with fade envelope.
// Holds shared types, register indexes, fixed-point constants and the gain math.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package stfe_pkg;

    // Default parameter values of the top level
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF = 32;
    localparam int OUT_BITS_DEF   = 24;

    // Field widths fixed by the register map
    localparam int COUNT_W     = 24;
    localparam int GAIN_W      = 32;
    localparam int AMP_W       = 24;
    localparam int STEP_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int Q_FRAC      = 30;
    localparam int AMP_FRAC    = 23;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Gain constants in Q2.30
    localparam logic [GAIN_W-1:0] ONE_Q30       = 32'h4000_0000;
    localparam logic [GAIN_W-1:0] EXP_FLOOR_Q30 = 32'd1073742;

    // Register reset values
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 32'd19685266;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 24'd4204670;
    localparam logic [COUNT_W-1:0] TOTAL_RST       = 24'd480000;
    localparam logic [COUNT_W-1:0] FADE_IN_LEN_RST = 24'd96000;
    localparam logic [COUNT_W-1:0] FADE_OUT_LEN_RST = 24'd96000;
    localparam logic               FADE_MODE_RST   = 1'b0;
    localparam logic [STEP_W-1:0]  FADE_IN_STEP_RST  = 32'd11185;
    localparam logic [STEP_W-1:0]  FADE_OUT_STEP_RST = 32'd11185;

    // Sine table generation constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int SERIES_TERMS = 12;
    localparam longint unsigned SERIES_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP    = 3'd0,
        CFG_AMPLITUDE     = 3'd1,
        CFG_TOTAL_SAMPLES = 3'd2,
        CFG_FADE_IN_LEN   = 3'd3,
        CFG_FADE_OUT_LEN  = 3'd4,
        CFG_FADE_MODE     = 3'd5,
        CFG_FADE_IN_STEP  = 3'd6,
        CFG_FADE_OUT_STEP = 3'd7
    } cfg_index_t;

    // Fade rule selected by the mode register
    typedef enum logic {
        FADE_LINEAR      = 1'b0,
        FADE_EXPONENTIAL = 1'b1
    } fade_mode_t;

    // Current register contents
    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [AMP_W-1:0]   amplitude;
        logic [COUNT_W-1:0] total_samples;
        logic [COUNT_W-1:0] fade_in_length;
        logic [COUNT_W-1:0] fade_out_length;
        fade_mode_t         fade_mode;
        logic [STEP_W-1:0]  fade_in_step;
        logic [STEP_W-1:0]  fade_out_step;
    } cfg_t;

    // Per-sample decisions made by the front and carried out by the back
    typedef struct packed {
        logic              ended;
        logic              last;
        logic              negative;
        logic              fade_in_on;
        logic              fade_out_on;
        logic              force_zero;
        logic [GAIN_W-1:0] fade_in_gain;
        logic [GAIN_W-1:0] fade_out_gain;
    } item_ctrl_t;

    // Index bits of the quarter-wave table: floor(log2(depth)), at most 16
    function automatic int tbl_log2(input int depth);
        int l;
        l = 0;
        for (int i = 0; i < 16; i++) begin
            if ((64'd2 << l) <= longint'(depth)) begin
                l = l + 1;
            end
        end
        return l;
    endfunction

    // One quarter-wave table entry, evaluated at elaboration only
    function automatic longint unsigned sine_entry(input longint unsigned k,
                                                   input int tbl_bits,
                                                   input longint unsigned max_mag);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        int n;
        x    = ((64'd2 * k + 64'd1) * HALF_PI_Q30) >> (tbl_bits + 1);
        x2   = (x * x) >> Q_FRAC;
        term = x;
        sum  = x;
        for (n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * x2) >> Q_FRAC) / SERIES_DIV[n - 1];
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum * max_mag + (64'd1 << 29)) >> Q_FRAC;
    endfunction

    // Q2.30 gain times Q2.30 coefficient, rounded, saturated to the gain width
    function automatic logic [GAIN_W-1:0] gain_mul(input logic [GAIN_W-1:0] g,
                                                   input logic [GAIN_W-1:0] c);
        localparam int PROD_W = 2 * GAIN_W + 1;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] shr;
        logic [GAIN_W-1:0] res;
        prod = PROD_W'(g) * PROD_W'(c) + (PROD_W'(1) << (Q_FRAC - 1));
        shr  = prod >> Q_FRAC;
        if (shr[PROD_W-1:GAIN_W] != '0) begin
            res = '1;
        end else begin
            res = shr[GAIN_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/stfe_front.sv */
// Front part of the tone generator: note position, phase and envelope gains.
// Decides everything about a sample when its tick is accepted.
// Depends on stfe_pkg.
module stfe_front #(
    parameter int PHASE_BITS = stfe_pkg::PHASE_BITS_DEF,
    parameter int TBL_BITS   = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    restart,
    input  stfe_pkg::cfg_t          cfg,
    output logic [TBL_BITS-1:0]     rom_addr,
    output stfe_pkg::item_ctrl_t    ctrl
);

    localparam int FB = TBL_BITS + 2;
    localparam int CW = stfe_pkg::COUNT_W;
    localparam int GW = stfe_pkg::GAIN_W;

    logic [CW-1:0]         index_reg, index_next, idx_base;
    logic [PHASE_BITS-1:0] phase_reg, phase_next, phase_base;
    logic [GW-1:0]         fi_gain_reg, fi_gain_next, fi_base;
    logic [GW-1:0]         fo_gain_reg, fo_gain_next, fo_base;
    logic [GW-1:0]         fi_mul, fi_lin, fi_after, fi_used;
    logic [GW-1:0]         fo_mul, fo_lin, fo_after, fo_used;
    logic [GW:0]           fi_sum;
    logic [CW:0]           idx_plus_one, fo_reach;
    logic [PHASE_BITS+FB-1:0] phase_wide;
    logic [FB-1:0]         phase_top;
    logic [TBL_BITS-1:0]   entry;
    logic                  ended, last, in_fi, in_fo, expo;

    // Restart takes effect before this tick's sample is formed
    always_comb
    begin
        expo       = (cfg.fade_mode == stfe_pkg::FADE_EXPONENTIAL);
        idx_base   = restart ? '0 : index_reg;
        phase_base = restart ? '0 : phase_reg;
        fi_base    = restart ? (expo ? stfe_pkg::EXP_FLOOR_Q30 : '0) : fi_gain_reg;
        fo_base    = restart ? stfe_pkg::ONE_Q30 : fo_gain_reg;
    end

    // Position of the sample within the note
    always_comb
    begin
        ended        = idx_base >= cfg.total_samples;
        idx_plus_one = {1'b0, idx_base} + (CW + 1)'(1);
        last         = idx_plus_one == {1'b0, cfg.total_samples};
        in_fi        = idx_base < cfg.fade_in_length;
        fo_reach     = {1'b0, idx_base} + {1'b0, cfg.fade_out_length};
        in_fo        = (cfg.fade_out_length != '0) &&
                       (fo_reach >= {1'b0, cfg.total_samples});
    end

    // Envelope gain updates for both fade rules
    always_comb
    begin
        fi_mul   = stfe_pkg::gain_mul(fi_base, cfg.fade_in_step);
        fo_mul   = stfe_pkg::gain_mul(fo_base, cfg.fade_out_step);
        fi_sum   = {1'b0, fi_base} + {1'b0, cfg.fade_in_step};
        fi_lin   = fi_sum[GW] ? '1 : fi_sum[GW-1:0];
        fo_lin   = (fo_base > cfg.fade_out_step) ? (fo_base - cfg.fade_out_step) : '0;
        // Exponential mode applies the updated gain, linear mode the old one
        fi_used  = expo ? fi_mul : fi_base;
        fi_after = expo ? fi_mul : fi_lin;
        fo_used  = expo ? fo_mul : fo_base;
        fo_after = expo ? fo_mul : fo_lin;
    end

    // Quadrant and table entry from the top phase bits
    always_comb
    begin
        phase_wide = {phase_base, {FB{1'b0}}};
        phase_top  = phase_wide[PHASE_BITS+FB-1 -: FB];
        entry      = phase_top[TBL_BITS-1:0];
        if (phase_top[TBL_BITS]) begin
            entry = ~entry;
        end
        rom_addr = entry;
    end

    // Decisions handed to the back
    always_comb
    begin
        ctrl.ended         = ended;
        ctrl.last          = last;
        ctrl.negative      = phase_top[FB-1];
        ctrl.fade_in_on    = in_fi;
        ctrl.fade_out_on   = in_fo;
        // Exponential fades start and finish on silence
        ctrl.force_zero    = expo && ((in_fi && (idx_base == '0)) || (in_fo && last));
        ctrl.fade_in_gain  = fi_used;
        ctrl.fade_out_gain = fo_used;
    end

    // Next state; an ended note keeps its state apart from a restart
    always_comb
    begin
        index_next   = ended ? idx_base : idx_plus_one[CW-1:0];
        phase_next   = ended ? phase_base : (phase_base + PHASE_BITS'(cfg.phase_step));
        fi_gain_next = (!ended && in_fi) ? fi_after : fi_base;
        fo_gain_next = (!ended && in_fo) ? fo_after : fo_base;
    end

    // Note state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            phase_reg   <= '0;
            fi_gain_reg <= '0;
            fo_gain_reg <= stfe_pkg::ONE_Q30;
        end
        else if (push)
        begin
            index_reg   <= index_next;
            phase_reg   <= phase_next;
            fi_gain_reg <= fi_gain_next;
            fo_gain_reg <= fo_gain_next;
        end
    end

endmodule

/* hw/rtl/stfe_queue.sv */
// Short queue between the front and the back of the tone generator.
// Holds the table address and the decisions for each accepted tick.
// Depends on stfe_pkg.
module stfe_queue #(
    parameter int ADDR_W = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ADDR_W-1:0]     push_addr,
    input  stfe_pkg::item_ctrl_t  push_ctrl,
    output logic                  ready,
    input  logic                  pop,
    output logic                  empty,
    output logic [ADDR_W-1:0]     head_addr,
    output stfe_pkg::item_ctrl_t  head_ctrl
);

    localparam int DEPTH = stfe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ADDR_W-1:0]    addr_mem_reg [DEPTH];
    stfe_pkg::item_ctrl_t ctrl_mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 full;

    // Occupancy and pointer updates
    always_comb
    begin
        full        = count_reg == CNT_W'(DEPTH);
        empty       = count_reg == '0;
        ready       = !full;
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PTR_W'(1));
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PTR_W'(1));
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
        head_addr = addr_mem_reg[rd_ptr_reg];
        head_ctrl = ctrl_mem_reg[rd_ptr_reg];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            addr_mem_reg[wr_ptr_reg] <= push_addr;
            ctrl_mem_reg[wr_ptr_reg] <= push_ctrl;
        end
    end

    // Occupancy never goes past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

    // Nothing is written into a full queue or taken from an empty one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && push) && !(empty && pop))
        else $error("queue overrun or underrun");

endmodule

/* hw/rtl/stfe_sine_rom.sv */
// Quarter-wave sine table of the tone generator, registered read port.
// Contents are generated at elaboration from the series in stfe_pkg.
// Depends on stfe_pkg.
module stfe_sine_rom #(
    parameter int TBL_BITS = 10,
    parameter int MAG_W    = 23
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [TBL_BITS-1:0] rd_addr,
    output logic [MAG_W-1:0]    rd_data
);

    localparam int TBL_DEPTH = 1 << TBL_BITS;

    typedef logic [MAG_W-1:0] rom_t [TBL_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        longint unsigned max_mag;
        max_mag = (64'd1 << MAG_W) - 64'd1;
        for (int k = 0; k < TBL_DEPTH; k++) begin
            r[k] = MAG_W'(stfe_pkg::sine_entry(longint'(k), TBL_BITS, max_mag));
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [MAG_W-1:0] rd_data_reg;

    // Registered table read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/stfe_back.sv */
// Back part of the tone generator: table read, amplitude and fade scaling, sign.
// A four-stage pipeline that advances whenever its output register is free.
// Depends on stfe_pkg and stfe_sine_rom.
module stfe_back #(
    parameter int TBL_BITS = 10,
    parameter int OUT_BITS = stfe_pkg::OUT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stfe_pkg::cfg_t        cfg,
    input  logic                  q_empty,
    input  logic [TBL_BITS-1:0]   q_addr,
    input  stfe_pkg::item_ctrl_t  q_ctrl,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [OUT_BITS-1:0] sample,
    output logic                  note_end,
    output logic                  active
);

    localparam int MAG_W = OUT_BITS - 1;
    localparam int GW    = stfe_pkg::GAIN_W;
    localparam int AP_W  = MAG_W + stfe_pkg::AMP_W + 1;
    localparam int SC_W  = MAG_W + GW + 1;

    logic                 adv;
    logic [MAG_W-1:0]     s1_mag;
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    stfe_pkg::item_ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    logic [MAG_W-1:0]     s2_mag_reg, s2_mag_next, s3_mag_reg, s3_mag_next;
    logic [MAG_W-1:0]     fo_mag, final_mag;
    logic [AP_W-1:0]      amp_prod, amp_shr;
    logic [SC_W-1:0]      fi_prod, fi_shr, fo_prod, fo_shr;
    logic [OUT_BITS-1:0]  sample_next;
    logic signed [OUT_BITS-1:0] sample_reg;
    logic                 note_end_reg, active_reg;

    // The whole pipeline moves when the output register is empty or taken
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    stfe_sine_rom #(
        .TBL_BITS (TBL_BITS),
        .MAG_W    (MAG_W)
    ) u_rom (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (q_addr),
        .rd_data (s1_mag)
    );

    // Amplitude scaling in Q1.23 with saturation
    always_comb
    begin
        amp_prod = AP_W'(s1_mag) * AP_W'(cfg.amplitude) +
                   (AP_W'(1) << (stfe_pkg::AMP_FRAC - 1));
        amp_shr  = amp_prod >> stfe_pkg::AMP_FRAC;
        if (amp_shr[AP_W-1:MAG_W] != '0) begin
            s2_mag_next = '1;
        end else begin
            s2_mag_next = amp_shr[MAG_W-1:0];
        end
    end

    // Fade-in gain in Q2.30 with saturation
    always_comb
    begin
        fi_prod = SC_W'(s2_mag_reg) * SC_W'(s2_ctrl_reg.fade_in_gain) +
                  (SC_W'(1) << (stfe_pkg::Q_FRAC - 1));
        fi_shr  = fi_prod >> stfe_pkg::Q_FRAC;
        if (!s2_ctrl_reg.fade_in_on) begin
            s3_mag_next = s2_mag_reg;
        end else if (fi_shr[SC_W-1:MAG_W] != '0) begin
            s3_mag_next = '1;
        end else begin
            s3_mag_next = fi_shr[MAG_W-1:0];
        end
    end

    // Fade-out gain, silence cases and sign
    always_comb
    begin
        fo_prod = SC_W'(s3_mag_reg) * SC_W'(s3_ctrl_reg.fade_out_gain) +
                  (SC_W'(1) << (stfe_pkg::Q_FRAC - 1));
        fo_shr  = fo_prod >> stfe_pkg::Q_FRAC;
        if (!s3_ctrl_reg.fade_out_on) begin
            fo_mag = s3_mag_reg;
        end else if (fo_shr[SC_W-1:MAG_W] != '0) begin
            fo_mag = '1;
        end else begin
            fo_mag = fo_shr[MAG_W-1:0];
        end
        final_mag = (s3_ctrl_reg.force_zero || s3_ctrl_reg.ended) ? '0 : fo_mag;
        if (s3_ctrl_reg.negative) begin
            sample_next = OUT_BITS'(0) - {1'b0, final_mag};
        end else begin
            sample_next = {1'b0, final_mag};
        end
    end

    // Valid bits of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctrl_reg  <= q_ctrl;
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_mag_reg   <= s2_mag_next;
            s3_ctrl_reg  <= s2_ctrl_reg;
            s3_mag_reg   <= s3_mag_next;
            sample_reg   <= sample_next;
            note_end_reg <= s3_ctrl_reg.last && !s3_ctrl_reg.ended;
            active_reg   <= !s3_ctrl_reg.ended;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign note_end  = note_end_reg;
    assign active    = active_reg;

    // A silent tick after the note carries no sample and no end mark
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !active_reg) |-> (sample_reg == '0) && !note_end_reg)
        else $error("ended note produced sound or an end mark");

    // A stalled output freezes the stages behind it
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid_reg) && $stable(s2_valid_reg) && $stable(s3_valid_reg))
        else $error("pipeline moved during an output stall");

endmodule

/* hw/rtl/sine_tone_with_fade_envelope_core.sv */
// Top level of the sine tone generator with fade-in and fade-out envelope.
// Holds the register file and connects front, queue and back; uses stfe_pkg.
//
// Usage: every request on the input channel (in_valid/in_ready, field restart)
// is one sample tick and yields exactly one request on the output channel
// (out_valid/out_ready, fields sample, note_end, active), in order. A tick with
// restart set starts a new note at sample zero and phase zero, and its own
// sample is the first one of that note. After the note's last sample the block
// keeps answering with silent, inactive samples until the next restart.
// Throughput: one tick per cycle while the output is not stalled; the gain and
// position update in the front is done once per accepted tick, and the table
// read and the three scaling multiplies each take one back-pipeline stage.
// When the receiver stalls, the back pipeline holds and the two-entry queue
// fills; in_ready drops once it is full. Registers are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while no tick is
// in flight, as the block does not enforce it. Reset puts every register at
// its default, the note at sample zero, and empties the pipeline.
module sine_tone_with_fade_envelope_core #(
    parameter int SINE_TABLE_DEPTH = stfe_pkg::SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = stfe_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS         = stfe_pkg::OUT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [stfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [OUT_BITS-1:0]          sample,
    output logic                                note_end,
    output logic                                active
);

    localparam int TBL_BITS = stfe_pkg::tbl_log2(SINE_TABLE_DEPTH);

    stfe_pkg::cfg_t       cfg_reg;
    stfe_pkg::item_ctrl_t front_ctrl, head_ctrl;
    logic [TBL_BITS-1:0]  front_addr, head_addr;
    logic                 push, pop, q_empty, q_ready;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step      <= stfe_pkg::PHASE_STEP_RST;
            cfg_reg.amplitude       <= stfe_pkg::AMPLITUDE_RST;
            cfg_reg.total_samples   <= stfe_pkg::TOTAL_RST;
            cfg_reg.fade_in_length  <= stfe_pkg::FADE_IN_LEN_RST;
            cfg_reg.fade_out_length <= stfe_pkg::FADE_OUT_LEN_RST;
            cfg_reg.fade_mode       <= stfe_pkg::fade_mode_t'(stfe_pkg::FADE_MODE_RST);
            cfg_reg.fade_in_step    <= stfe_pkg::FADE_IN_STEP_RST;
            cfg_reg.fade_out_step   <= stfe_pkg::FADE_OUT_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (stfe_pkg::cfg_index_t'(cfg_index))
                stfe_pkg::CFG_PHASE_STEP:
                    cfg_reg.phase_step <= cfg_data[stfe_pkg::STEP_W-1:0];
                stfe_pkg::CFG_AMPLITUDE:
                    cfg_reg.amplitude <= cfg_data[stfe_pkg::AMP_W-1:0];
                stfe_pkg::CFG_TOTAL_SAMPLES:
                    cfg_reg.total_samples <= cfg_data[stfe_pkg::COUNT_W-1:0];
                stfe_pkg::CFG_FADE_IN_LEN:
                    cfg_reg.fade_in_length <= cfg_data[stfe_pkg::COUNT_W-1:0];
                stfe_pkg::CFG_FADE_OUT_LEN:
                    cfg_reg.fade_out_length <= cfg_data[stfe_pkg::COUNT_W-1:0];
                stfe_pkg::CFG_FADE_MODE:
                    cfg_reg.fade_mode <= stfe_pkg::fade_mode_t'(cfg_data[0]);
                stfe_pkg::CFG_FADE_IN_STEP:
                    cfg_reg.fade_in_step <= cfg_data[stfe_pkg::STEP_W-1:0];
                stfe_pkg::CFG_FADE_OUT_STEP:
                    cfg_reg.fade_out_step <= cfg_data[stfe_pkg::STEP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A tick is taken whenever the queue has room
    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    stfe_front #(
        .PHASE_BITS (PHASE_BITS),
        .TBL_BITS   (TBL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .restart  (restart),
        .cfg      (cfg_reg),
        .rom_addr (front_addr),
        .ctrl     (front_ctrl)
    );

    stfe_queue #(
        .ADDR_W (TBL_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_addr (front_addr),
        .push_ctrl (front_ctrl),
        .ready     (q_ready),
        .pop       (pop),
        .empty     (q_empty),
        .head_addr (head_addr),
        .head_ctrl (head_ctrl)
    );

    stfe_back #(
        .TBL_BITS (TBL_BITS),
        .OUT_BITS (OUT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_addr    (head_addr),
        .q_ctrl    (head_ctrl),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .note_end  (note_end),
        .active    (active)
    );

endmodule
